// ===== design/jsu_pkg.sv =====
// Package for the JSON string unescaper: status codes, character constants,
// the packet type passed between front and back, and the decode helpers.
// No dependencies.
`default_nettype none

package jsu_pkg;

  localparam logic [2:0] ST_BYTE       = 3'd0;
  localparam logic [2:0] ST_END        = 3'd1;
  localparam logic [2:0] ST_NO_QUOTE   = 3'd2;
  localparam logic [2:0] ST_BAD_ESC    = 3'd3;
  localparam logic [2:0] ST_BAD_UNI    = 3'd4;
  localparam logic [2:0] ST_BAD_SURR   = 3'd5;
  localparam logic [2:0] ST_UNTERM_STR = 3'd6;
  localparam logic [2:0] ST_UNTERM_ESC = 3'd7;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  typedef enum logic [6:0] {
    M_IDLE = 7'b0000001,
    M_STR  = 7'b0000010,
    M_ESC  = 7'b0000100,
    M_HEX1 = 7'b0001000,
    M_SBS  = 7'b0010000,
    M_SU   = 7'b0100000,
    M_HEX2 = 7'b1000000
  } mode_t;

  // Results of one input: nbytes data bytes, then an optional status entry.
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
    logic            has_status;
    logic [2:0]      status;
  } pkt_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } utf8_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      d = {1'b0, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      d = {1'b0, c[3:0] + 4'd9};
    end
    return d;
  endfunction

  // Bit 8 set marks an escape letter that is not a simple escape.
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] v;
    case (c)
      8'h22:   v = 9'h022;
      8'h5c:   v = 9'h05c;
      8'h2f:   v = 9'h02f;
      8'h62:   v = 9'h008;
      8'h66:   v = 9'h00c;
      8'h6e:   v = 9'h00a;
      8'h72:   v = 9'h00d;
      8'h74:   v = 9'h009;
      default: v = 9'h100;
    endcase
    return v;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r.b = '0;
    if (cp <= 21'h7f) begin
      r.n    = 3'd1;
      r.b[0] = {1'b0, cp[6:0]};
    end else if (cp <= 21'h7ff) begin
      r.n    = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      r.n    = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.n    = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/jsu_in_if.sv =====
// Input channel of the JSON string unescaper: one text byte per transaction.
// No dependencies.
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== design/jsu_out_if.sv =====
// Output channel of the JSON string unescaper: one result per transaction.
// No dependencies.
`default_nettype none

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

`default_nettype wire

// ===== design/jsu_front.sv =====
// Front end: accepts text bytes, runs the string parser state machine and
// builds one result packet per byte. Depends on jsu_pkg and jsu_in_if.
`default_nettype none

module jsu_front
  import jsu_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  jsu_in_if.sink      in_ch,
  input  wire         full,
  output logic        push,
  output pkt_t        pkt
);

  mode_t       mode, mode_next;
  logic [15:0] acc, acc_next;
  logic [1:0]  cnt, cnt_next;
  logic [9:0]  hs, hs_next;

  logic [7:0]  b;
  logic        eot;
  logic [4:0]  d;
  logic [8:0]  esc;
  logic [15:0] acc_new;
  logic [20:0] cp;
  utf8_t       enc;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;
  assign b           = in_ch.text_byte;
  assign eot         = in_ch.end_of_text;
  assign d           = hex_digit(b);
  assign esc         = esc_map(b);
  assign acc_new     = {acc[11:0], d[3:0]};
  assign cp          = (mode == M_HEX1) ? {5'd0, acc_new}
                                        : ({1'b0, hs, acc_new[9:0]} + SUPP_BASE);
  assign enc         = utf8_enc(cp);

  always_comb begin
    mode_next      = mode;
    acc_next       = acc;
    cnt_next       = cnt;
    hs_next        = hs;
    pkt.nbytes     = 3'd0;
    pkt.bytes      = '0;
    pkt.has_status = 1'b0;
    pkt.status     = ST_BYTE;
    case (mode)
      M_STR: begin
        if (b == CH_QUOTE) begin
          pkt.has_status = 1'b1;
          pkt.status     = ST_END;
          mode_next      = M_IDLE;
        end else if (b == CH_BSLASH) begin
          pkt.has_status = eot;
          pkt.status     = ST_UNTERM_ESC;
          mode_next      = M_ESC;
        end else begin
          pkt.nbytes     = 3'd1;
          pkt.bytes[0]   = b;
          pkt.has_status = eot;
          pkt.status     = ST_UNTERM_STR;
        end
      end
      M_ESC: begin
        if (!esc[8]) begin
          pkt.nbytes     = 3'd1;
          pkt.bytes[0]   = esc[7:0];
          pkt.has_status = eot;
          pkt.status     = ST_UNTERM_STR;
          mode_next      = M_STR;
        end else if (b == CH_U) begin
          acc_next       = '0;
          cnt_next       = '0;
          pkt.has_status = eot;
          pkt.status     = ST_BAD_UNI;
          mode_next      = M_HEX1;
        end else begin
          pkt.has_status = 1'b1;
          pkt.status     = ST_BAD_ESC;
          mode_next      = M_IDLE;
        end
      end
      M_HEX1, M_HEX2: begin
        if (d[4]) begin
          pkt.has_status = 1'b1;
          pkt.status     = ST_BAD_UNI;
          mode_next      = M_IDLE;
        end else begin
          acc_next = acc_new;
          if (cnt != 2'd3) begin
            cnt_next       = cnt + 2'd1;
            pkt.has_status = eot;
            pkt.status     = (mode == M_HEX1) ? ST_BAD_UNI : ST_BAD_SURR;
          end else begin
            cnt_next = '0;
            if (mode == M_HEX1 && acc_new[15:10] == SURR_HIGH_TAG) begin
              hs_next        = acc_new[9:0];
              pkt.has_status = eot;
              pkt.status     = ST_BAD_SURR;
              mode_next      = M_SBS;
            end else if ((mode == M_HEX1) == (acc_new[15:10] == SURR_LOW_TAG)) begin
              pkt.has_status = 1'b1;
              pkt.status     = ST_BAD_SURR;
              mode_next      = M_IDLE;
            end else begin
              pkt.nbytes     = enc.n;
              pkt.bytes      = enc.b;
              pkt.has_status = eot;
              pkt.status     = ST_UNTERM_STR;
              mode_next      = M_STR;
            end
          end
        end
      end
      M_SBS: begin
        if (b != CH_BSLASH || eot) begin
          pkt.has_status = 1'b1;
          pkt.status     = ST_BAD_SURR;
          mode_next      = M_IDLE;
        end else begin
          mode_next = M_SU;
        end
      end
      M_SU: begin
        if (b != CH_U || eot) begin
          pkt.has_status = 1'b1;
          pkt.status     = ST_BAD_SURR;
          mode_next      = M_IDLE;
        end else begin
          acc_next  = '0;
          cnt_next  = '0;
          mode_next = M_HEX2;
        end
      end
      default: begin
        if (b != CH_QUOTE) begin
          pkt.has_status = 1'b1;
          pkt.status     = ST_NO_QUOTE;
          mode_next      = M_IDLE;
        end else if (eot) begin
          pkt.has_status = 1'b1;
          pkt.status     = ST_UNTERM_STR;
          mode_next      = M_IDLE;
        end else begin
          mode_next = M_STR;
        end
      end
    endcase
    if (eot) begin
      mode_next = M_IDLE;
    end
    // A byte that produces nothing still yields a single zero byte.
    if (pkt.nbytes == 3'd0 && !pkt.has_status) begin
      pkt.nbytes = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      acc  <= '0;
      cnt  <= '0;
      hs   <= '0;
    end else if (push) begin
      mode <= mode_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
      hs   <= hs_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/jsu_queue.sv =====
// Two-entry packet queue between the front end and the output serializer.
// Depends on jsu_pkg.
`default_nettype none

module jsu_queue
  import jsu_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   push,
  input  pkt_t  wr_pkt,
  input  wire   pop,
  output logic  full,
  output logic  head_valid,
  output pkt_t  head
);

  pkt_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/jsu_back.sv =====
// Back end: walks the head packet into the output register, one result per
// cycle while out_ch accepts. Depends on jsu_pkg and jsu_out_if.
`default_nettype none

module jsu_back
  import jsu_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        head_valid,
  input  pkt_t       head,
  output logic       pop,
  jsu_out_if.source  out_ch
);

  logic       ovalid;
  logic [7:0] obyte;
  logic [2:0] ostatus;
  logic       olast;
  logic [2:0] idx;
  logic [2:0] total;
  logic       load;
  logic       is_last;

  assign total   = head.nbytes + {2'b00, head.has_status};
  assign is_last = (idx == total - 3'd1);
  assign load    = head_valid && (!ovalid || out_ch.ready);
  assign pop     = load && is_last;

  assign out_ch.valid    = ovalid;
  assign out_ch.out_byte = obyte;
  assign out_ch.status   = ostatus;
  assign out_ch.last     = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= 3'd0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        idx    <= is_last ? 3'd0 : idx + 3'd1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      olast <= is_last;
      if (idx < head.nbytes) begin
        obyte   <= head.bytes[idx[1:0]];
        ostatus <= ST_BYTE;
      end else begin
        obyte   <= 8'h00;
        ostatus <= head.status;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/json_string_unescape_utf8.sv =====
// JSON string unescaper to UTF-8, top level.
// Input channel in_ch carries one JSON text byte and an end-of-text flag per
// transaction, starting at the opening quote of a string. Output channel
// out_ch carries result transactions: a decoded byte (status 0), or a status
// code for string end or an error; last marks the final result of one input.
// Each input byte yields one to five results, in order.
// An accepted byte's packet is written into the queue and its first result
// then loaded into the output register. Throughput: one input byte per cycle
// while each byte yields a single result and out_ch is ready; a \uXXXX escape
// that completes a code point yields one result per UTF-8 byte, which the
// output serializer drains one result per cycle.
// A two-entry packet queue separates the parser from the serializer, so
// in_ch stays ready while a result waits in the output register; when the
// receiver stalls, the queue fills and in_ch.ready drops.
// Reset (rst, synchronous) returns the parser to waiting for an opening
// quote and empties the queue and the output register.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_queue, jsu_back.
`default_nettype none

module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  logic push;
  pkt_t wr_pkt;
  logic full;
  logic pop;
  logic head_valid;
  pkt_t head;

  jsu_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .pkt   (wr_pkt)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_pkt     (wr_pkt),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/json_string_unescape_utf8_tb.sv =====
`timescale 1ns / 1ps
// Testbench for json_string_unescape_utf8: feeds quoted JSON text, one byte per
// transaction, and checks every result against a built-in string decoder.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and the json_string_unescape_utf8 design.

module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 243;
  localparam int DIRECTED_ROWS = 27;

  typedef struct packed {
    logic [7:0] text;
    logic       eot;
    logic       typed;
    logic [7:0] want_byte;
    logic [2:0] want_status;
  } text_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] status;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    P_IDLE, P_STR, P_ESC, P_HEX1, P_LOW_BSLASH, P_LOW_U, P_HEX2
  } parse_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8 dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  parse_state_t parse_state = P_IDLE;
  logic [15:0]  hex_acc     = '0;
  logic [1:0]   digits_seen = '0;
  logic [9:0]   high_bits   = '0;

  result_t   step_results[$];
  result_t   expected_results[$];
  text_row_t text_rows[$];
  text_row_t cur_row;

  int texts_taken   = 0;
  int results_taken = 0;
  int mismatches    = 0;
  int cycle_count   = 0;
  bit feed_calm     = 1'b0;
  bit drain_calm    = 1'b0;

  logic [7:0] escape_letters [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};

  text_row_t directed_rows [DIRECTED_ROWS] = '{
    {"a",       1'b0, 1'b1, 8'h00, ST_NO_QUOTE},
    {8'h00,     1'b0, 1'b1, 8'h00, ST_NO_QUOTE},
    {CH_QUOTE,  1'b1, 1'b1, 8'h00, ST_UNTERM_STR},
    {CH_QUOTE,  1'b0, 1'b1, 8'h00, ST_BYTE},
    {8'h00,     1'b0, 1'b1, 8'h00, ST_BYTE},
    {8'hff,     1'b0, 1'b1, 8'hff, ST_BYTE},
    {CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_BYTE},
    {"t",       1'b0, 1'b0, 8'h00, ST_BYTE},
    {CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_BYTE},
    {CH_U,      1'b0, 1'b0, 8'h00, ST_BYTE},
    {"D",       1'b0, 1'b0, 8'h00, ST_BYTE},
    {"8",       1'b0, 1'b0, 8'h00, ST_BYTE},
    {"3",       1'b0, 1'b0, 8'h00, ST_BYTE},
    {"D",       1'b0, 1'b0, 8'h00, ST_BYTE},
    {CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_BYTE},
    {CH_U,      1'b0, 1'b0, 8'h00, ST_BYTE},
    {"d",       1'b0, 1'b0, 8'h00, ST_BYTE},
    {"e",       1'b0, 1'b0, 8'h00, ST_BYTE},
    {"0",       1'b0, 1'b0, 8'h00, ST_BYTE},
    {"0",       1'b0, 1'b0, 8'h00, ST_BYTE},
    {CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_BYTE},
    {"q",       1'b0, 1'b1, 8'h00, ST_BAD_ESC},
    {CH_QUOTE,  1'b0, 1'b0, 8'h00, ST_BYTE},
    {CH_BSLASH, 1'b1, 1'b1, 8'h00, ST_UNTERM_ESC},
    {CH_QUOTE,  1'b0, 1'b0, 8'h00, ST_BYTE},
    {CH_QUOTE,  1'b0, 1'b1, 8'h00, ST_END},
    {8'hff,     1'b1, 1'b1, 8'h00, ST_NO_QUOTE}
  };

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h10;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
    return v[4:0];
  endfunction

  function automatic logic [8:0] escape_value(input logic [7:0] c);
    case (c)
      CH_QUOTE:  return {1'b0, CH_QUOTE};
      CH_BSLASH: return {1'b0, CH_BSLASH};
      "/":       return 9'h02f;
      "b":       return 9'h008;
      "f":       return 9'h00c;
      "n":       return 9'h00a;
      "r":       return 9'h00d;
      "t":       return 9'h009;
      default:   return 9'h100;
    endcase
  endfunction

  task automatic add_result(input logic [7:0] data, input logic [2:0] status);
    result_t r;
    r = {data, status, 1'b0};
    step_results.insert(step_results.size(), r);
  endtask

  task automatic add_code_point(input logic [20:0] cp);
    if (cp <= 21'h7f) begin
      add_result(cp[7:0], ST_BYTE);
    end else if (cp <= 21'h7ff) begin
      add_result(8'hc0 | cp[10:6], ST_BYTE);
      add_result(8'h80 | cp[5:0], ST_BYTE);
    end else if (cp <= 21'hffff) begin
      add_result(8'he0 | cp[15:12], ST_BYTE);
      add_result(8'h80 | cp[11:6], ST_BYTE);
      add_result(8'h80 | cp[5:0], ST_BYTE);
    end else begin
      add_result(8'hf0 | cp[20:18], ST_BYTE);
      add_result(8'h80 | cp[17:12], ST_BYTE);
      add_result(8'h80 | cp[11:6], ST_BYTE);
      add_result(8'h80 | cp[5:0], ST_BYTE);
    end
  endtask

  task automatic decode_text(input logic [7:0] b, input logic eot);
    logic [8:0]  simple;
    logic [4:0]  nib;
    logic [15:0] quad;
    step_results.delete();
    case (parse_state)
      P_STR: begin
        if (b == CH_QUOTE) begin
          add_result(8'h00, ST_END);
          parse_state = P_IDLE;
        end else if (b == CH_BSLASH) begin
          if (eot) add_result(8'h00, ST_UNTERM_ESC);
          parse_state = P_ESC;
        end else begin
          add_result(b, ST_BYTE);
          if (eot) add_result(8'h00, ST_UNTERM_STR);
        end
      end
      P_ESC: begin
        simple = escape_value(b);
        if (!simple[8]) begin
          add_result(simple[7:0], ST_BYTE);
          if (eot) add_result(8'h00, ST_UNTERM_STR);
          parse_state = P_STR;
        end else if (b == CH_U) begin
          hex_acc = '0;
          digits_seen = '0;
          if (eot) add_result(8'h00, ST_BAD_UNI);
          parse_state = P_HEX1;
        end else begin
          add_result(8'h00, ST_BAD_ESC);
          parse_state = P_IDLE;
        end
      end
      P_HEX1, P_HEX2: begin
        nib = nibble_of(b);
        if (nib[4]) begin
          add_result(8'h00, ST_BAD_UNI);
          parse_state = P_IDLE;
        end else begin
          hex_acc = {hex_acc[11:0], nib[3:0]};
          quad = hex_acc;
          if (digits_seen != 2'd3) begin
            digits_seen = digits_seen + 2'd1;
            if (eot) add_result(8'h00, (parse_state == P_HEX1) ? ST_BAD_UNI : ST_BAD_SURR);
          end else begin
            digits_seen = '0;
            if (parse_state == P_HEX1 && quad >= 16'hd800 && quad <= 16'hdbff) begin
              high_bits = quad[9:0];
              if (eot) add_result(8'h00, ST_BAD_SURR);
              parse_state = P_LOW_BSLASH;
            end else if (parse_state == P_HEX1 && quad >= 16'hdc00 && quad <= 16'hdfff) begin
              add_result(8'h00, ST_BAD_SURR);
              parse_state = P_IDLE;
            end else if (parse_state == P_HEX2 && (quad < 16'hdc00 || quad > 16'hdfff)) begin
              add_result(8'h00, ST_BAD_SURR);
              parse_state = P_IDLE;
            end else begin
              if (parse_state == P_HEX1) add_code_point({5'd0, quad});
              else add_code_point(21'h10000 + {1'b0, high_bits, quad[9:0]});
              if (eot) add_result(8'h00, ST_UNTERM_STR);
              parse_state = P_STR;
            end
          end
        end
      end
      P_LOW_BSLASH: begin
        if (b != CH_BSLASH || eot) begin
          add_result(8'h00, ST_BAD_SURR);
          parse_state = P_IDLE;
        end else begin
          parse_state = P_LOW_U;
        end
      end
      P_LOW_U: begin
        if (b != CH_U || eot) begin
          add_result(8'h00, ST_BAD_SURR);
          parse_state = P_IDLE;
        end else begin
          hex_acc = '0;
          digits_seen = '0;
          parse_state = P_HEX2;
        end
      end
      default: begin
        if (b != CH_QUOTE) add_result(8'h00, ST_NO_QUOTE);
        else if (eot) add_result(8'h00, ST_UNTERM_STR);
        else parse_state = P_STR;
      end
    endcase
    if (eot) parse_state = P_IDLE;
    if (step_results.size() == 0) add_result(8'h00, ST_BYTE);
  endtask

  task automatic push_text(input logic [7:0] b);
    text_row_t row;
    row = {b, 1'b0, 1'b0, 8'h00, ST_BYTE};
    text_rows.insert(text_rows.size(), row);
  endtask

  task automatic end_text_here();
    text_rows[text_rows.size() - 1].eot = 1'b1;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = "0" + n;
    else if ($urandom_range(0, 1) != 0) c = "A" + n - 8'd10;
    else c = "a" + n - 8'd10;
    return c;
  endfunction

  task automatic push_quad(input logic [15:0] v);
    for (int i = 3; i >= 0; i--) push_text(hex_char(v[i*4 +: 4]));
  endtask

  task automatic push_unicode(input logic [15:0] v);
    push_text(CH_BSLASH);
    push_text(CH_U);
    push_quad(v);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [15:0] bmp_code_point();
    logic [15:0] v;
    case ($urandom_range(0, 2))
      0: v = 16'($urandom_range(0, 16'h7f));
      1: v = 16'($urandom_range(16'h80, 16'h7ff));
      default: begin
        do v = 16'($urandom_range(16'h800, 16'hffff));
        while (v >= 16'hd800 && v <= 16'hdfff);
      end
    endcase
    if ($urandom_range(0, 9) == 0) v = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
    return v;
  endfunction

  function automatic logic [15:0] high_half();
    return 16'($urandom_range(16'hd800, 16'hdbff));
  endfunction

  // Mostly well-formed strings with random content; some end in one fault,
  // some are cut short by end of text, and a few are noise outside a string.
  task automatic build_string();
    int          start, pieces, cut;
    logic [7:0]  b;
    logic [8:0]  ev;
    logic [4:0]  nib;
    logic [15:0] hi, lo;
    text_row_t   spare;
    start = text_rows.size();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4)) push_text(8'($urandom_range(0, 255)));
      end_text_here();
      return;
    end
    push_text(CH_QUOTE);
    pieces = $urandom_range(0, 6);
    for (int i = 0; i < pieces; i++) begin
      case ($urandom_range(0, 6))
        0, 1, 2: push_text(plain_byte());
        3: begin
          push_text(CH_BSLASH);
          push_text(escape_letters[3'($urandom_range(0, 7))]);
        end
        4: push_unicode(bmp_code_point());
        default: begin
          hi = high_half();
          lo = 16'($urandom_range(16'hdc00, 16'hdfff));
          case ($urandom_range(0, 7))
            0: begin hi = 16'hd800; lo = 16'hdc00; end
            1: begin hi = 16'hdbff; lo = 16'hdfff; end
            default: ;
          endcase
          push_unicode(hi);
          push_unicode(lo);
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0: begin
          push_text(CH_BSLASH);
          do begin
            b = 8'($urandom_range(0, 255));
            ev = escape_value(b);
          end while (!ev[8] || b == CH_U);
          push_text(b);
        end
        1: begin
          if ($urandom_range(0, 1) != 0) push_unicode(high_half());
          push_text(CH_BSLASH);
          push_text(CH_U);
          repeat ($urandom_range(0, 3)) push_text(hex_char(4'($urandom_range(0, 15))));
          do begin
            b = 8'($urandom_range(0, 255));
            nib = nibble_of(b);
          end while (!nib[4]);
          push_text(b);
        end
        2: push_unicode(16'($urandom_range(16'hdc00, 16'hdfff)));
        3: begin
          push_unicode(high_half());
          do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
          push_text(b);
        end
        4: begin
          push_unicode(high_half());
          push_text(CH_BSLASH);
          do b = 8'($urandom_range(0, 255)); while (b == CH_U);
          push_text(b);
        end
        default: begin
          push_unicode(high_half());
          do lo = 16'($urandom_range(0, 16'hffff));
          while (lo >= 16'hdc00 && lo <= 16'hdfff);
          push_unicode(lo);
        end
      endcase
    end else begin
      push_text(CH_QUOTE);
    end
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(start + 1, text_rows.size());
      while (text_rows.size() > cut) spare = text_rows.pop_back();
      end_text_here();
    end
  endtask

  function automatic int draw_gap(input bit calm);
    if (calm) return 0;
    return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 18) : $urandom_range(0, 2);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("%0t: result %0d: %s", $time, results_taken, what);
  endtask

  always @(posedge clk) begin : predict_results
    result_t r;
    if (!rst && in_ch.valid && in_ch.ready) begin
      decode_text(cur_row.text, cur_row.eot);
      if (cur_row.typed) begin
        step_results.delete();
        add_result(cur_row.want_byte, cur_row.want_status);
      end
      foreach (step_results[i]) begin
        r = step_results[i];
        r.last = (i == step_results.size() - 1);
        expected_results.insert(expected_results.size(), r);
      end
      texts_taken++;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_taken++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, byte %02h status %0d",
                                  out_ch.out_byte, out_ch.status));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.out_byte !== want.data)
          report_mismatch($sformatf("out_byte %02h, predicted %02h", out_ch.out_byte, want.data));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d", out_ch.status, want.status));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, predicted %0b", out_ch.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : drain_results
    int gap;
    int seen;
    out_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) drain_calm = !drain_calm;
      gap = draw_gap(drain_calm);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      seen = results_taken;
      do @(negedge clk); while (results_taken == seen);
    end
  end

  initial begin : feed_text
    int gap;
    in_ch.valid = 1'b0;
    in_ch.text_byte = '0;
    in_ch.end_of_text = 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++) text_rows.insert(text_rows.size(), directed_rows[i]);
    while (text_rows.size() < DIRECTED_ROWS + RANDOM_ITEMS) build_string();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (text_rows[i]) begin
      if ($urandom_range(0, 19) == 0) feed_calm = !feed_calm;
      gap = draw_gap(feed_calm);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      cur_row = text_rows[i];
      in_ch.text_byte <= cur_row.text;
      in_ch.end_of_text <= cur_row.eot;
      in_ch.valid <= 1'b1;
      do @(negedge clk); while (texts_taken != i + 1);
    end
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
